// ===== src/ubxfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// UBX frame receive checker package
// Transaction types, sync bytes and result codes shared by the checker files.
// ----------------------------------------------------------------------------
package ubxfrc_pkg;

   localparam logic [15:0] SYNC_WORD = 16'h62b5;
   localparam logic [7:0]  SYNC_CHAR_1 = SYNC_WORD[7:0];
   localparam logic [7:0]  SYNC_CHAR_2 = SYNC_WORD[15:8];

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_TYPE    = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd1;
   localparam logic [2:0] STATUS_LOST_SYNC = 3'd2;
   localparam logic [2:0] STATUS_LEN_WRONG = 3'd3;
   localparam logic [2:0] STATUS_CHECKSUM  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic [7:0] expected_len;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       frame_done;
      logic [2:0] status;
   } rsp_type;

endpackage

// ===== src/ubx_frame_receive_checker.sv =====
// ----------------------------------------------------------------------------
// UBX frame receive checker
// Checks received UBX frames byte by byte and reports a status per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per transaction and returns one result per
// byte, in the cycle after the byte is accepted, from a single result register.
// A new byte can be accepted every cycle as long as the result register is
// empty or is being drained in the same cycle; the position, checksum and
// length update is a single pass of two 8-bit adds and a few compares. The
// result passes class, id and payload bytes on and, on the last checksum
// byte, flags the frame done with its status.
module ubx_frame_receive_checker #(
   parameter int MAX_FRAME = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ubxfrc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ubxfrc_pkg::rsp_type rsp_data
);
   import ubxfrc_pkg::*;

   logic    accept;
   rsp_type rsp_next;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   ubxfrc_frame_tracker #(
      .MAX_FRAME(MAX_FRAME)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .rsp_next(rsp_next)
   );

   always_comb begin
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = accept ? rsp_next : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/ubxfrc_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// UBX frame tracker
// Keeps the byte position, Fletcher sums and captured length of the frame in
// progress and forms the result for each accepted byte.
// ----------------------------------------------------------------------------
module ubxfrc_frame_tracker #(
   parameter int MAX_FRAME = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  ubxfrc_pkg::req_type req,
   output ubxfrc_pkg::rsp_type rsp_next
);
   import ubxfrc_pkg::*;

   localparam logic [8:0] MAX_FRAME_BYTES = 9'(MAX_FRAME);

   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  exp_ff, exp_in;
   logic [15:0] cap_len_ff, cap_len_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic        ck_a_ok_ff, ck_a_ok_in;
   logic        sync_bad_ff, sync_bad_in;

   logic [8:0]  pos;
   logic [8:0]  len_ext;
   logic [7:0]  sum_a_cur, sum_b_cur;
   logic [15:0] cap_len_cur;
   logic        ck_a_ok_cur, sync_bad_cur;
   logic [7:0]  sum_a_add, sum_b_add;

   always_comb begin
      pos     = req.frame_start ? 9'd0 : pos_ff;
      exp_in  = req.frame_start ? req.expected_len : exp_ff;
      len_ext = {1'b0, exp_in};

      if (pos == 9'd0) begin
         sum_a_cur    = '0;
         sum_b_cur    = '0;
         cap_len_cur  = '0;
         ck_a_ok_cur  = 1'b0;
         sync_bad_cur = 1'b0;
      end else begin
         sum_a_cur    = sum_a_ff;
         sum_b_cur    = sum_b_ff;
         cap_len_cur  = cap_len_ff;
         ck_a_ok_cur  = ck_a_ok_ff;
         sync_bad_cur = sync_bad_ff;
      end

      sum_a_add = sum_a_cur + req.data_byte;
      sum_b_add = sum_b_cur + sum_a_add;

      sum_a_in    = sum_a_cur;
      sum_b_in    = sum_b_cur;
      cap_len_in  = cap_len_cur;
      ck_a_ok_in  = ck_a_ok_cur;
      sync_bad_in = sync_bad_cur;
      rsp_next    = '0;

      if (pos == 9'd0) begin
         if (req.data_byte != SYNC_CHAR_1) sync_bad_in = 1'b1;
      end else if (pos == 9'd1) begin
         if (req.data_byte != SYNC_CHAR_2) sync_bad_in = 1'b1;
      end else if (pos <= len_ext + 9'd5) begin
         sum_a_in = sum_a_add;
         sum_b_in = sum_b_add;
         if (pos == 9'd2 || pos == 9'd3) begin
            rsp_next.out_kind = KIND_TYPE;
            rsp_next.out_byte = req.data_byte;
         end else if (pos == 9'd4) begin
            cap_len_in[7:0] = req.data_byte;
         end else if (pos == 9'd5) begin
            cap_len_in[15:8] = req.data_byte;
         end else begin
            rsp_next.out_kind = KIND_PAYLOAD;
            rsp_next.out_byte = req.data_byte;
         end
      end else if (pos == len_ext + 9'd6) begin
         ck_a_ok_in = (req.data_byte == sum_a_cur);
      end else begin
         rsp_next.frame_done = 1'b1;
         if (len_ext + 9'd8 > MAX_FRAME_BYTES) begin
            rsp_next.status = STATUS_TOO_LONG;
         end else if (sync_bad_cur) begin
            rsp_next.status = STATUS_LOST_SYNC;
         end else if (cap_len_cur != {8'd0, exp_in}) begin
            rsp_next.status = STATUS_LEN_WRONG;
         end else if (!ck_a_ok_cur || req.data_byte != sum_b_cur) begin
            rsp_next.status = STATUS_CHECKSUM;
         end else begin
            rsp_next.status = STATUS_OK;
         end
      end

      pos_in = rsp_next.frame_done ? 9'd0 : pos + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         exp_ff      <= '0;
         cap_len_ff  <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         ck_a_ok_ff  <= 1'b0;
         sync_bad_ff <= 1'b0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         exp_ff      <= exp_in;
         cap_len_ff  <= cap_len_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         ck_a_ok_ff  <= ck_a_ok_in;
         sync_bad_ff <= sync_bad_in;
      end
   end

`ifndef ASSERT_OFF
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= {1'b0, exp_ff} + 9'd7)
      else $error("byte position ran past the end of the frame");

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_next.frame_done |=> pos_ff == 9'd0)
      else $error("position not cleared after a finished frame");

   a_done_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_next.frame_done |-> rsp_next.out_kind == KIND_NONE)
      else $error("finished frame also passed a byte on");
`endif

endmodule
